>>> rtl/rad_pkg.sv
package rad_pkg;

    // Line store depth: dst_cols above this is clamped to it, so output columns beyond it are not produced.
    localparam int MAX_DST_COLS = 1024;
    localparam int ADDR_W       = $clog2(MAX_DST_COLS);
    localparam int FILL_W       = ADDR_W + 1;

    localparam int NUM_CH     = 4;
    localparam int CH_W       = 8;
    localparam int DIM_W      = 13;
    localparam int DCOL_W     = 11;
    localparam int STEP_W     = 15;
    localparam int RECIP_W    = 9;
    localparam int LEFT_W     = 9;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = 32;
    localparam int WGT_W      = STEP_W;
    localparam int TOTAL_W    = DCOL_W + DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Weight of one whole source pixel in 7.8 fixed point.
    localparam logic [WGT_W-1:0] UNIT_WEIGHT = WGT_W'(256);
    localparam logic [CH_W-1:0]  CH_MAX      = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_COLS       = 3'd0,
        CFG_SRC_ROWS       = 3'd1,
        CFG_DST_COLS       = 3'd2,
        CFG_DST_ROWS       = 3'd3,
        CFG_COL_STEP       = 3'd4,
        CFG_COL_STEP_RECIP = 3'd5,
        CFG_ROW_STEP       = 3'd6,
        CFG_ROW_STEP_RECIP = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   src_cols;
        logic [DIM_W-1:0]   src_rows;
        logic [DCOL_W-1:0]  dst_cols;
        logic [DIM_W-1:0]   dst_rows;
        logic [STEP_W-1:0]  col_step;
        logic [RECIP_W-1:0] col_step_recip;
        logic [STEP_W-1:0]  row_step;
        logic [RECIP_W-1:0] row_step_recip;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_COL,
        ST_AVG,
        ST_FOLD,
        ST_SCALE
    } t_state;

    typedef struct packed {
        logic accept;
        logic init;
        logic col;
        logic avg;
        logic fold;
        logic scale;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic col_split;
        logic row_split;
        logic out_free;
    } t_sts;

    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [WGT_W-1:0]        weight;
        t_sum [NUM_CH-1:0]       sums;
    } t_entry;

    // Weight left for the next output after the boundary pixel gave away its share.
    function automatic logic [WGT_W-1:0] carry_weight(input logic [STEP_W-1:0] step,
                                                      input logic [LEFT_W-1:0] left);
        logic [STEP_W-1:0] left_ext;
        left_ext = STEP_W'(left);
        if (step >= left_ext) begin
            return step - left_ext;
        end
        return '0;
    endfunction

endpackage

>>> rtl/rad_in_if.sv
interface rad_in_if;
    logic                    valid;
    logic                    ready;
    logic [rad_pkg::CH_W-1:0] red_in;
    logic [rad_pkg::CH_W-1:0] green_in;
    logic [rad_pkg::CH_W-1:0] blue_in;
    logic [rad_pkg::CH_W-1:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

>>> rtl/rad_out_if.sv
interface rad_out_if;
    logic                    valid;
    logic                    ready;
    logic [rad_pkg::CH_W-1:0] red_out;
    logic [rad_pkg::CH_W-1:0] green_out;
    logic [rad_pkg::CH_W-1:0] blue_out;
    logic [rad_pkg::CH_W-1:0] alpha_out;
    logic                    last_of_frame;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output last_of_frame, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input last_of_frame, output ready);
endinterface

>>> rtl/rad_cfg_regs.sv
module rad_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rad_pkg::t_cfg                   o_cfg
);

    rad_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_cols       <= rad_pkg::DIM_W'(1280);
            r_cfg.src_rows       <= rad_pkg::DIM_W'(720);
            r_cfg.dst_cols       <= rad_pkg::DCOL_W'(640);
            r_cfg.dst_rows       <= rad_pkg::DIM_W'(360);
            r_cfg.col_step       <= rad_pkg::STEP_W'(512);
            r_cfg.col_step_recip <= rad_pkg::RECIP_W'(128);
            r_cfg.row_step       <= rad_pkg::STEP_W'(512);
            r_cfg.row_step_recip <= rad_pkg::RECIP_W'(128);
        end else if (i_cfg_we) begin
            case (rad_pkg::t_cfg_idx'(i_cfg_idx))
                rad_pkg::CFG_SRC_COLS: begin
                    r_cfg.src_cols <= i_cfg_data[rad_pkg::DIM_W-1:0];
                end
                rad_pkg::CFG_SRC_ROWS: begin
                    r_cfg.src_rows <= i_cfg_data[rad_pkg::DIM_W-1:0];
                end
                rad_pkg::CFG_DST_COLS: begin
                    r_cfg.dst_cols <= i_cfg_data[rad_pkg::DCOL_W-1:0];
                end
                rad_pkg::CFG_DST_ROWS: begin
                    r_cfg.dst_rows <= i_cfg_data[rad_pkg::DIM_W-1:0];
                end
                rad_pkg::CFG_COL_STEP: begin
                    r_cfg.col_step <= i_cfg_data[rad_pkg::STEP_W-1:0];
                end
                rad_pkg::CFG_COL_STEP_RECIP: begin
                    r_cfg.col_step_recip <= i_cfg_data[rad_pkg::RECIP_W-1:0];
                end
                rad_pkg::CFG_ROW_STEP: begin
                    r_cfg.row_step <= i_cfg_data[rad_pkg::STEP_W-1:0];
                end
                rad_pkg::CFG_ROW_STEP_RECIP: begin
                    r_cfg.row_step_recip <= i_cfg_data[rad_pkg::RECIP_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/rad_ctrl.sv
module rad_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rad_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output rad_pkg::t_cmd  o_cmd
);

    rad_pkg::t_state r_state;
    rad_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rad_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = rad_pkg::ST_INIT;
                end
            end
            rad_pkg::ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = rad_pkg::ST_COL;
            end
            rad_pkg::ST_COL: begin
                o_cmd.col = 1'b1;
                // Only a pixel that closes an output column goes on to the line store.
                if (i_sts.active && i_sts.col_split) begin
                    n_state = rad_pkg::ST_AVG;
                end else begin
                    n_state = rad_pkg::ST_IDLE;
                end
            end
            rad_pkg::ST_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = rad_pkg::ST_FOLD;
            end
            rad_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (i_sts.row_split) begin
                    n_state = rad_pkg::ST_SCALE;
                end else begin
                    n_state = rad_pkg::ST_IDLE;
                end
            end
            rad_pkg::ST_SCALE: begin
                if (i_sts.out_free) begin
                    o_cmd.scale = 1'b1;
                    n_state     = rad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rad_datapath.sv
module rad_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rad_pkg::t_cfg               i_cfg,
    input  rad_pkg::t_cmd               i_cmd,
    output rad_pkg::t_sts               o_sts,
    input  logic [rad_pkg::CH_W-1:0]    i_red,
    input  logic [rad_pkg::CH_W-1:0]    i_green,
    input  logic [rad_pkg::CH_W-1:0]    i_blue,
    input  logic [rad_pkg::CH_W-1:0]    i_alpha,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [rad_pkg::CH_W-1:0]    o_red,
    output logic [rad_pkg::CH_W-1:0]    o_green,
    output logic [rad_pkg::CH_W-1:0]    o_blue,
    output logic [rad_pkg::CH_W-1:0]    o_alpha,
    output logic                        o_last
);

    localparam int NCH     = rad_pkg::NUM_CH;
    localparam int CW      = rad_pkg::CH_W;
    localparam int SW      = rad_pkg::SUM_W;
    localparam int FW      = rad_pkg::FRAC_W;
    localparam int AVGP_W  = SW + 1 + rad_pkg::RECIP_W;
    localparam int PROD_W  = SW + rad_pkg::LEFT_W;

    // Control state.
    logic [rad_pkg::DIM_W-1:0]    r_src_col;
    logic [rad_pkg::DIM_W-1:0]    r_src_row;
    logic [rad_pkg::DCOL_W-1:0]   r_out_col;
    logic [rad_pkg::TOTAL_W-1:0]  r_opc;
    logic [rad_pkg::FILL_W-1:0]   r_fill;
    logic                         r_out_valid;

    // Working registers.
    logic [NCH-1:0][CW-1:0]       r_ch;
    logic [rad_pkg::TOTAL_W-1:0]  r_total;
    logic [rad_pkg::WGT_W-1:0]    r_col_weight;
    rad_pkg::t_sum [NCH-1:0]      r_run;
    logic [rad_pkg::STEP_W-1:0]   r_frame_rstep;
    logic [NCH-1:0][SW:0]         r_t;
    logic [rad_pkg::ADDR_W-1:0]   r_addr;
    rad_pkg::t_sum [NCH-1:0]      r_avg;
    logic [rad_pkg::WGT_W-1:0]    r_w;
    rad_pkg::t_sum [NCH-1:0]      r_sum;
    rad_pkg::t_sum [NCH-1:0]      r_fsum;
    logic [NCH-1:0][CW-1:0]       r_out_ch;
    logic                         r_out_last;

    // Line store: row weight and four channel sums per output column.
    rad_pkg::t_entry              mem [rad_pkg::MAX_DST_COLS];
    rad_pkg::t_entry              r_rd;
    rad_pkg::t_entry              wdata;

    logic [rad_pkg::DCOL_W-1:0]   eff_cols;
    logic [rad_pkg::DIM_W-1:0]    src_cols_eff;
    logic [rad_pkg::DIM_W-1:0]    src_rows_eff;
    logic [rad_pkg::DIM_W:0]      col_inc;
    logic [rad_pkg::DIM_W:0]      row_inc;
    logic [rad_pkg::TOTAL_W-1:0]  total_next;
    logic                         row_start;
    logic                         frame_start;
    logic                         active;
    logic                         col_split;
    logic                         row_split;
    logic                         hit;
    logic [rad_pkg::LEFT_W-1:0]   left_c;
    logic [rad_pkg::LEFT_W-1:0]   left_r;
    logic [NCH-1:0][SW:0]         t_next;
    rad_pkg::t_sum [NCH-1:0]      run_split;
    rad_pkg::t_sum [NCH-1:0]      run_acc;
    logic [NCH-1:0][AVGP_W-1:0]   avg_prod;
    rad_pkg::t_sum [NCH-1:0]      avg_next;
    logic [NCH-1:0][PROD_W-1:0]   w_prod;
    logic [NCH-1:0][PROD_W-1:0]   rem_prod;
    logic [NCH-1:0][PROD_W-1:0]   s_prod;
    rad_pkg::t_sum [NCH-1:0]      s_emit;
    rad_pkg::t_sum [NCH-1:0]      s_acc;
    rad_pkg::t_sum [NCH-1:0]      s_rem;
    logic [NCH-1:0][CW-1:0]       clamp;

    always_comb begin
        if (i_cfg.dst_cols > rad_pkg::DCOL_W'(rad_pkg::MAX_DST_COLS)) begin
            eff_cols = rad_pkg::DCOL_W'(rad_pkg::MAX_DST_COLS);
        end else begin
            eff_cols = i_cfg.dst_cols;
        end
        src_cols_eff = (i_cfg.src_cols == '0) ? rad_pkg::DIM_W'(1) : i_cfg.src_cols;
        src_rows_eff = (i_cfg.src_rows == '0) ? rad_pkg::DIM_W'(1) : i_cfg.src_rows;
        col_inc      = {1'b0, r_src_col} + 1'b1;
        row_inc      = {1'b0, r_src_row} + 1'b1;
        total_next   = eff_cols * i_cfg.dst_rows;
        row_start    = (r_src_col == '0);
        frame_start  = row_start && (r_src_row == '0);
        active       = (r_opc < r_total) && (r_out_col < eff_cols);
        col_split    = (r_col_weight <= rad_pkg::UNIT_WEIGHT);
        row_split    = (r_w <= rad_pkg::UNIT_WEIGHT);
        hit          = ({1'b0, r_addr} < r_fill);
        left_c       = rad_pkg::LEFT_W'(rad_pkg::UNIT_WEIGHT - r_col_weight);
        left_r       = rad_pkg::LEFT_W'(rad_pkg::UNIT_WEIGHT - r_w);
    end

    // Four independent channel lanes.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            t_next[k]    = {1'b0, r_run[k]} + (r_col_weight[rad_pkg::LEFT_W-1:0] * r_ch[k]);
            run_split[k] = left_c * r_ch[k];
            run_acc[k]   = r_run[k] + (SW'(r_ch[k]) << FW);
            avg_prod[k]  = r_t[k] * i_cfg.col_step_recip;
            avg_next[k]  = avg_prod[k][SW+FW-1:FW];
            w_prod[k]    = r_w[rad_pkg::LEFT_W-1:0] * r_avg[k];
            rem_prod[k]  = left_r * r_avg[k];
            s_emit[k]    = r_sum[k] + w_prod[k][SW+FW-1:FW];
            s_rem[k]     = rem_prod[k][SW+FW-1:FW];
            s_acc[k]     = r_sum[k] + r_avg[k];
            s_prod[k]    = r_fsum[k] * i_cfg.row_step_recip;
            if (|s_prod[k][PROD_W-1:2*FW+CW]) begin
                clamp[k] = rad_pkg::CH_MAX;
            end else begin
                clamp[k] = s_prod[k][2*FW+CW-1:2*FW];
            end
        end
    end

    always_comb begin
        if (row_split) begin
            wdata.weight = rad_pkg::carry_weight(i_cfg.row_step, left_r);
            wdata.sums   = s_rem;
        end else begin
            wdata.weight = r_w - rad_pkg::UNIT_WEIGHT;
            wdata.sums   = s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fold) begin
            mem[r_addr] <= wdata;
        end
        if (i_cmd.col) begin
            r_rd <= mem[r_out_col[rad_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_out_col   <= '0;
            r_opc       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                if (col_inc >= {1'b0, src_cols_eff}) begin
                    r_src_col <= '0;
                    if (row_inc >= {1'b0, src_rows_eff}) begin
                        r_src_row <= '0;
                    end else begin
                        r_src_row <= row_inc[rad_pkg::DIM_W-1:0];
                    end
                end else begin
                    r_src_col <= col_inc[rad_pkg::DIM_W-1:0];
                end
                if (row_start) begin
                    r_out_col <= '0;
                end
                // Entries at or beyond the fill count read as the frame start values.
                if (frame_start) begin
                    r_fill <= '0;
                    r_opc  <= '0;
                end
            end
            if (i_cmd.col && active && col_split) begin
                r_out_col <= r_out_col + 1'b1;
            end
            if (i_cmd.fold) begin
                if (!hit) begin
                    r_fill <= rad_pkg::FILL_W'(r_addr) + 1'b1;
                end
                if (row_split) begin
                    r_opc <= r_opc + 1'b1;
                end
            end
            if (i_cmd.scale) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch <= {i_alpha, i_blue, i_green, i_red};
        end
        if (i_cmd.init) begin
            r_total <= total_next;
            if (row_start) begin
                r_col_weight <= i_cfg.col_step;
                r_run        <= '0;
            end
            if (frame_start) begin
                r_frame_rstep <= i_cfg.row_step;
            end
        end
        if (i_cmd.col && active) begin
            if (col_split) begin
                r_t          <= t_next;
                r_run        <= run_split;
                r_col_weight <= rad_pkg::carry_weight(i_cfg.col_step, left_c);
                r_addr       <= r_out_col[rad_pkg::ADDR_W-1:0];
            end else begin
                r_run        <= run_acc;
                r_col_weight <= r_col_weight - rad_pkg::UNIT_WEIGHT;
            end
        end
        if (i_cmd.avg) begin
            r_avg <= avg_next;
            r_w   <= hit ? r_rd.weight : r_frame_rstep;
            r_sum <= hit ? r_rd.sums : '0;
        end
        if (i_cmd.fold && row_split) begin
            r_fsum <= s_emit;
        end
        if (i_cmd.scale) begin
            r_out_ch   <= clamp;
            r_out_last <= (r_opc == r_total);
        end
    end

    assign o_sts.active    = active;
    assign o_sts.col_split = col_split;
    assign o_sts.row_split = row_split;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_ch[0];
    assign o_green     = r_out_ch[1];
    assign o_blue      = r_out_ch[2];
    assign o_alpha     = r_out_ch[3];
    assign o_last      = r_out_last;

    // Columns are folded in order from zero within a row, so a fold never skips past the fill.
    a_fold_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fold |-> ({1'b0, r_addr} <= r_fill))
        else $error("line store fold beyond fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= rad_pkg::FILL_W'(rad_pkg::MAX_DST_COLS))
        else $error("fill count exceeds line store depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scale |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    a_scale_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scale |=> r_out_valid)
        else $error("scaled pixel not presented");

endmodule

>>> rtl/rgba_area_downscaler_unit.sv
// Area-averaging RGBA downscaler. Source pixels arrive in raster order as words on i_pix;
// downscaled pixels leave on o_pix, with last_of_frame set on the final pixel of a frame.
// A frame starts with the first source pixel after reset or after the previous frame's
// src_rows*src_cols pixels. Each pixel is handled by one pass of the controller, and the next
// pixel is accepted only once that pass has ended. A pixel that only accumulates into the
// running column sum, or that lies outside the output, passes through the init and column
// states, the column state also reading the line store; one that closes an output column goes
// on through the column average multiply and the row fold, and one that also completes an
// output pixel then waits in the scale state until the output word is free. The 1024-entry
// line store needs no clearing pass: a fill count marks the columns already written in the current frame.
// Configuration may be written only while no pixel is in flight.
module rgba_area_downscaler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rad_in_if.sink                          i_pix,
    rad_out_if.source                       o_pix
);

    rad_pkg::t_cfg cfg;
    rad_pkg::t_cmd cmd;
    rad_pkg::t_sts sts;
    logic          in_ready;

    rad_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rad_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_alpha     (i_pix.alpha_in),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .o_red       (o_pix.red_out),
        .o_green     (o_pix.green_out),
        .o_blue      (o_pix.blue_out),
        .o_alpha     (o_pix.alpha_out),
        .o_last      (o_pix.last_of_frame)
    );

    assign i_pix.ready = in_ready;

endmodule
